[rtl/rtps_pkg.sv]
// Shared types and constants of the priority task scheduler.
package rtps_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_PRIO_LEVELS = 32;

  localparam logic [7:0] DEPTH_MAX = 8'd255;
  localparam logic [7:0] SLICE_RST = 8'd10;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] REG_SLICE_RELOAD = 2'd0;

  typedef enum logic [2:0] {
    CMD_CREATE,
    CMD_DELAY,
    CMD_TICK,
    CMD_SUSPEND,
    CMD_RESUME,
    CMD_DELETE,
    CMD_LOCK,
    CMD_UNLOCK
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DEC,
    S_WSCAN,
    S_WCHK,
    S_WAKE,
    S_SLICE,
    S_PSCAN,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_EXEC,
    DP_DEC,
    DP_WSCAN,
    DP_WAKE,
    DP_SLICE,
    DP_PSCAN,
    DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic wfound;
  } dp_stat_t;

endpackage

[rtl/rtps_ctrl.sv]
// Control state machine that sequences the scheduler datapath.
module rtps_ctrl import rtps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op = DP_NOP;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op = DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.op = DP_EXEC;
        state_nxt = stat.is_tick ? S_DEC : S_PSCAN;
      end
      S_DEC: begin
        ctl.op = DP_DEC;
        if (stat.scan_last) state_nxt = S_WSCAN;
      end
      S_WSCAN: begin
        ctl.op = DP_WSCAN;
        if (stat.scan_last) state_nxt = S_WCHK;
      end
      S_WCHK: begin
        state_nxt = stat.wfound ? S_WAKE : S_SLICE;
      end
      S_WAKE: begin
        ctl.op = DP_WAKE;
        state_nxt = S_WSCAN;
      end
      S_SLICE: begin
        ctl.op = DP_SLICE;
        state_nxt = S_PSCAN;
      end
      S_PSCAN: begin
        ctl.op = DP_PSCAN;
        if (stat.scan_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          ctl.op = DP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/rtps_dpath.sv]
// Task slot state, command execution, slot scans and result registers.
module rtps_dpath import rtps_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     ctl,
  output dp_stat_t    stat,
  input  logic [7:0]  slice_reload,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_task_id,
  input  logic [4:0]  in_priority_req,
  input  logic [15:0] in_delay_ticks,
  output logic        out_switch_request,
  output logic [3:0]  out_next_task,
  output logic [3:0]  out_current_task,
  output logic [1:0]  out_status
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(PRIO_LEVELS);
  localparam logic [PW-1:0] PRIO_LOW = PW'(PRIO_LEVELS - 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_TASKS - 1);

  logic          valid_r   [MAX_TASKS];
  logic [PW-1:0] prio_r    [MAX_TASKS];
  logic [15:0]   dleft_r   [MAX_TASKS];
  logic          delayed_r [MAX_TASKS];
  logic          susp_r    [MAX_TASKS];
  logic [7:0]    sdepth_r  [MAX_TASKS];
  logic [7:0]    slice_r   [MAX_TASKS];
  logic [31:0]   rstamp_r  [MAX_TASKS];
  logic [31:0]   dstamp_r  [MAX_TASKS];
  logic          waking_r  [MAX_TASKS];

  logic [31:0]   ocnt_r;
  logic [7:0]    lock_r;
  logic [IW-1:0] run_r;
  cmd_t          cmd_r;
  logic [3:0]    id_r;
  logic [4:0]    preq_r;
  logic [15:0]   ticks_r;
  logic [1:0]    st_r;
  logic [IW-1:0] cnt_r;
  logic          found_r;
  logic [IW-1:0] best_r;
  logic [PW-1:0] bprio_r;
  logic [31:0]   bstamp_r;
  logic          wfound_r;
  logic [IW-1:0] wbest_r;
  logic [31:0]   wstamp_r;

  logic          sw_r;
  logic [3:0]    nxt_task_r;
  logic [3:0]    cur_task_r;
  logic [1:0]    ost_r;

  logic          id_ok;
  logic [IW-1:0] sid;
  logic [IW-1:0] idx;
  logic          rd_ready;
  logic [7:0]    reload;
  logic [PW-1:0] prio_sat;
  logic          scanning;
  logic [IW-1:0] pick;
  logic          do_sw;

  assign id_ok = 32'(id_r) < 32'(MAX_TASKS);
  assign sid = IW'(id_r);
  assign reload = (slice_reload == 8'd0) ? 8'd1 : slice_reload;
  assign prio_sat = (32'(preq_r) > 32'(PRIO_LEVELS - 1)) ? PRIO_LOW : PW'(preq_r);
  assign scanning = (ctl.op == DP_DEC) || (ctl.op == DP_WSCAN) || (ctl.op == DP_PSCAN);

  always_comb begin
    case (ctl.op)
      DP_DEC, DP_WSCAN, DP_PSCAN: idx = cnt_r;
      DP_WAKE: idx = wbest_r;
      DP_SLICE: idx = run_r;
      DP_EXEC: idx = (cmd_r == CMD_DELAY) ? run_r : sid;
      default: idx = sid;
    endcase
  end

  assign rd_ready = valid_r[idx] && !delayed_r[idx] && !susp_r[idx];
  assign pick = found_r ? best_r : run_r;
  assign do_sw = found_r && (lock_r == 8'd0) && (best_r != run_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_TASKS; s++) begin
        valid_r[s] <= (s == 0);
        prio_r[s] <= (s == 0) ? PRIO_LOW : '0;
        dleft_r[s] <= '0;
        delayed_r[s] <= 1'b0;
        susp_r[s] <= 1'b0;
        sdepth_r[s] <= '0;
        slice_r[s] <= SLICE_RST;
        rstamp_r[s] <= '0;
        dstamp_r[s] <= '0;
        waking_r[s] <= 1'b0;
      end
      ocnt_r <= 32'd1;
      lock_r <= '0;
      run_r <= '0;
      cnt_r <= '0;
      found_r <= 1'b0;
      wfound_r <= 1'b0;
    end else begin
      cnt_r <= (scanning && !(cnt_r == LAST_SLOT)) ? cnt_r + 1'b1 : '0;
      case (ctl.op)
        DP_LOAD: begin
          cmd_r <= cmd_t'(in_command);
          id_r <= in_task_id;
          preq_r <= in_priority_req;
          ticks_r <= in_delay_ticks;
        end
        DP_EXEC: begin
          found_r <= 1'b0;
          wfound_r <= 1'b0;
          st_r <= ST_DONE;
          case (cmd_r)
            CMD_CREATE: begin
              if (!id_ok) st_r <= ST_INVALID;
              else if (valid_r[idx]) st_r <= ST_IGNORED;
              else begin
                valid_r[idx] <= 1'b1;
                prio_r[idx] <= prio_sat;
                dleft_r[idx] <= '0;
                delayed_r[idx] <= 1'b0;
                susp_r[idx] <= 1'b0;
                sdepth_r[idx] <= '0;
                slice_r[idx] <= reload;
                dstamp_r[idx] <= '0;
                rstamp_r[idx] <= ocnt_r;
                ocnt_r <= ocnt_r + 32'd1;
              end
            end
            CMD_DELAY: begin
              if (!rd_ready) st_r <= ST_IGNORED;
              else begin
                dleft_r[idx] <= (ticks_r == 16'd0) ? 16'd1 : ticks_r;
                delayed_r[idx] <= 1'b1;
                dstamp_r[idx] <= ocnt_r;
                ocnt_r <= ocnt_r + 32'd1;
              end
            end
            CMD_SUSPEND: begin
              if (!id_ok || !valid_r[idx]) st_r <= ST_INVALID;
              else if (delayed_r[idx]) st_r <= ST_IGNORED;
              else if (susp_r[idx]) begin
                if (sdepth_r[idx] < DEPTH_MAX) sdepth_r[idx] <= sdepth_r[idx] + 8'd1;
              end else begin
                susp_r[idx] <= 1'b1;
                sdepth_r[idx] <= 8'd1;
              end
            end
            CMD_RESUME: begin
              if (!id_ok || !valid_r[idx]) st_r <= ST_INVALID;
              else if (!susp_r[idx]) st_r <= ST_IGNORED;
              else if (sdepth_r[idx] <= 8'd1) begin
                sdepth_r[idx] <= '0;
                susp_r[idx] <= 1'b0;
                rstamp_r[idx] <= ocnt_r;
                ocnt_r <= ocnt_r + 32'd1;
              end else begin
                sdepth_r[idx] <= sdepth_r[idx] - 8'd1;
              end
            end
            CMD_DELETE: begin
              if (!id_ok || !valid_r[idx]) st_r <= ST_INVALID;
              else begin
                valid_r[idx] <= 1'b0;
                delayed_r[idx] <= 1'b0;
                susp_r[idx] <= 1'b0;
                sdepth_r[idx] <= '0;
                dleft_r[idx] <= '0;
              end
            end
            CMD_LOCK: begin
              if (lock_r >= DEPTH_MAX) st_r <= ST_IGNORED;
              else lock_r <= lock_r + 8'd1;
            end
            CMD_UNLOCK: begin
              if (lock_r == 8'd0) st_r <= ST_IGNORED;
              else lock_r <= lock_r - 8'd1;
            end
            default: ;
          endcase
        end
        DP_DEC: begin
          if (valid_r[idx] && delayed_r[idx]) begin
            if (dleft_r[idx] <= 16'd1) begin
              dleft_r[idx] <= '0;
              waking_r[idx] <= 1'b1;
            end else begin
              dleft_r[idx] <= dleft_r[idx] - 16'd1;
            end
          end
        end
        DP_WSCAN: begin
          if (waking_r[idx] && (!wfound_r || dstamp_r[idx] > wstamp_r)) begin
            wfound_r <= 1'b1;
            wbest_r <= idx;
            wstamp_r <= dstamp_r[idx];
          end
        end
        DP_WAKE: begin
          wfound_r <= 1'b0;
          waking_r[idx] <= 1'b0;
          delayed_r[idx] <= 1'b0;
          rstamp_r[idx] <= ocnt_r;
          ocnt_r <= ocnt_r + 32'd1;
        end
        DP_SLICE: begin
          found_r <= 1'b0;
          if (valid_r[idx]) begin
            if (slice_r[idx] <= 8'd1) begin
              slice_r[idx] <= reload;
              if (rd_ready) begin
                rstamp_r[idx] <= ocnt_r;
                ocnt_r <= ocnt_r + 32'd1;
              end
            end else begin
              slice_r[idx] <= slice_r[idx] - 8'd1;
            end
          end
        end
        DP_PSCAN: begin
          if (rd_ready && (!found_r || prio_r[idx] < bprio_r ||
              (prio_r[idx] == bprio_r && rstamp_r[idx] < bstamp_r))) begin
            found_r <= 1'b1;
            best_r <= idx;
            bprio_r <= prio_r[idx];
            bstamp_r <= rstamp_r[idx];
          end
        end
        DP_COMMIT: begin
          if (do_sw) run_r <= best_r;
          sw_r <= do_sw;
          nxt_task_r <= 4'(pick);
          cur_task_r <= do_sw ? 4'(best_r) : 4'(run_r);
          ost_r <= st_r;
        end
        default: ;
      endcase
    end
  end

  assign stat.is_tick = (cmd_r == CMD_TICK);
  assign stat.scan_last = (cnt_r == LAST_SLOT);
  assign stat.wfound = wfound_r;

  assign out_switch_request = sw_r;
  assign out_next_task = nxt_task_r;
  assign out_current_task = cur_task_r;
  assign out_status = ost_r;

endmodule

[rtl/rtos_priority_task_scheduler_core.sv]
// Top level of the priority task scheduler with round-robin time slicing.
//
// Requests enter on the in_ channel (valid/ready) and each produces exactly
// one result on the out_ channel (valid/ready). The slice_reload register is
// written through the APB-style port at byte address 0 and read back there.
// A request is taken only while the block is idle. A non-tick request is
// executed and then passes the selection scan, which visits one task slot
// per cycle, before its result is registered. The next request is taken
// only once that result has been registered, so requests never overlap.
// A tick adds, before the selection scan, a countdown scan of all slots, a
// wake scan, a wake step and a further wake scan for each task that wakes,
// and the slice update of the running task.
// The result sits in an output register; if the receiver stalls, the block
// holds it and waits before finishing the next request.
// Reset is synchronous: slot 0 holds the ready idle task at the lowest
// priority and is running, the lock depth is zero, the stamp counter is one
// and slice_reload is ten.
module rtos_priority_task_scheduler_core import rtps_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_task_id,
  input  logic [4:0]  in_priority_req,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_switch_request,
  output logic [3:0]  out_next_task,
  output logic [3:0]  out_current_task,
  output logic [1:0]  out_status
);

  logic [7:0] reload_r;
  dp_cmd_t    ctl;
  dp_stat_t   stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= SLICE_RST;
    end else if (psel && penable && pwrite && (paddr == REG_SLICE_RELOAD)) begin
      reload_r <= pwdata[7:0];
    end
  end

  assign prdata = {24'd0, reload_r};

  rtps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rtps_dpath #(
    .MAX_TASKS   (MAX_TASKS),
    .PRIO_LEVELS (PRIO_LEVELS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .slice_reload       (reload_r),
    .in_command         (in_command),
    .in_task_id         (in_task_id),
    .in_priority_req    (in_priority_req),
    .in_delay_ticks     (in_delay_ticks),
    .out_switch_request (out_switch_request),
    .out_next_task      (out_next_task),
    .out_current_task   (out_current_task),
    .out_status         (out_status)
  );

  a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request |-> out_next_task == out_current_task)
    else $error("switch result names a different running task");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule

[bench/rtos_priority_task_scheduler_core_tb.sv]
// Self-checking testbench for the priority task scheduler core.
`timescale 1ns / 1ps

module rtos_priority_task_scheduler_core_tb import rtps_pkg::*; ();

  localparam int NSLOTS = 16;

  typedef struct packed {
    logic       switch_request;
    logic [3:0] next_task;
    logic [3:0] current_task;
    logic [1:0] status;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [3:0]  in_task_id = '0;
  logic [4:0]  in_priority_req = '0;
  logic [15:0] in_delay_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_switch_request;
  logic [3:0]  out_next_task;
  logic [3:0]  out_current_task;
  logic [1:0]  out_status;

  rtos_priority_task_scheduler_core dut (.*);

  always #5 clk = ~clk;

  // Scheduler state as predicted.
  logic [7:0]  m_slice_reload;
  logic        m_valid [NSLOTS];
  logic [4:0]  m_prio [NSLOTS];
  logic [15:0] m_delay_left [NSLOTS];
  logic        m_delayed [NSLOTS];
  logic        m_susp [NSLOTS];
  logic [7:0]  m_susp_depth [NSLOTS];
  logic [7:0]  m_slice_left [NSLOTS];
  logic [31:0] m_ready_stamp [NSLOTS];
  logic [31:0] m_delay_stamp [NSLOTS];
  logic [31:0] m_counter;
  logic [7:0]  m_lock;
  logic [3:0]  m_running;

  sched_result_t pending_results[$];
  int errors = 0;
  int burst_left = 0;

  function automatic logic slot_ready(int s);
    return m_valid[s] && !m_delayed[s] && !m_susp[s];
  endfunction

  function automatic logic [7:0] reload_ticks();
    return (m_slice_reload == 8'd0) ? 8'd1 : m_slice_reload;
  endfunction

  function automatic sched_result_t schedule_model(cmd_t c, logic [3:0] id, logic [4:0] pr,
                                                    logic [15:0] dt);
    sched_result_t r;
    logic [NSLOTS-1:0] waking;
    int w;
    int best;
    r = '0;
    r.status = ST_DONE;
    case (c)
      CMD_CREATE: begin
        if (m_valid[id]) begin
          r.status = ST_IGNORED;
        end else begin
          m_valid[id] = 1'b1;
          m_prio[id] = pr;
          m_delay_left[id] = '0;
          m_delayed[id] = 1'b0;
          m_susp[id] = 1'b0;
          m_susp_depth[id] = '0;
          m_slice_left[id] = reload_ticks();
          m_delay_stamp[id] = '0;
          m_ready_stamp[id] = m_counter;
          m_counter++;
        end
      end
      CMD_DELAY: begin
        if (!slot_ready(m_running)) begin
          r.status = ST_IGNORED;
        end else begin
          m_delay_left[m_running] = (dt == 16'd0) ? 16'd1 : dt;
          m_delayed[m_running] = 1'b1;
          m_delay_stamp[m_running] = m_counter;
          m_counter++;
        end
      end
      CMD_TICK: begin
        waking = '0;
        for (int s = 0; s < NSLOTS; s++) begin
          if (m_valid[s] && m_delayed[s]) begin
            if (m_delay_left[s] <= 16'd1) begin
              m_delay_left[s] = '0;
              waking[s] = 1'b1;
            end else begin
              m_delay_left[s]--;
            end
          end
        end
        do begin
          w = -1;
          for (int s = 0; s < NSLOTS; s++) begin
            if (waking[s] && (w < 0 || m_delay_stamp[s] > m_delay_stamp[w])) w = s;
          end
          if (w >= 0) begin
            waking[w] = 1'b0;
            m_delayed[w] = 1'b0;
            m_ready_stamp[w] = m_counter;
            m_counter++;
          end
        end while (w >= 0);
        if (m_valid[m_running]) begin
          if (m_slice_left[m_running] <= 8'd1) begin
            m_slice_left[m_running] = reload_ticks();
            if (slot_ready(m_running)) begin
              m_ready_stamp[m_running] = m_counter;
              m_counter++;
            end
          end else begin
            m_slice_left[m_running]--;
          end
        end
      end
      CMD_SUSPEND: begin
        if (!m_valid[id]) begin
          r.status = ST_INVALID;
        end else if (m_delayed[id]) begin
          r.status = ST_IGNORED;
        end else if (m_susp[id]) begin
          if (m_susp_depth[id] < DEPTH_MAX) m_susp_depth[id]++;
        end else begin
          m_susp[id] = 1'b1;
          m_susp_depth[id] = 8'd1;
        end
      end
      CMD_RESUME: begin
        if (!m_valid[id]) begin
          r.status = ST_INVALID;
        end else if (!m_susp[id]) begin
          r.status = ST_IGNORED;
        end else if (m_susp_depth[id] <= 8'd1) begin
          m_susp_depth[id] = '0;
          m_susp[id] = 1'b0;
          m_ready_stamp[id] = m_counter;
          m_counter++;
        end else begin
          m_susp_depth[id]--;
        end
      end
      CMD_DELETE: begin
        if (!m_valid[id]) begin
          r.status = ST_INVALID;
        end else begin
          m_valid[id] = 1'b0;
          m_delayed[id] = 1'b0;
          m_susp[id] = 1'b0;
          m_susp_depth[id] = '0;
          m_delay_left[id] = '0;
        end
      end
      CMD_LOCK: begin
        if (m_lock >= DEPTH_MAX) r.status = ST_IGNORED;
        else m_lock++;
      end
      default: begin
        if (m_lock == 8'd0) r.status = ST_IGNORED;
        else m_lock--;
      end
    endcase
    best = -1;
    for (int s = 0; s < NSLOTS; s++) begin
      if (slot_ready(s) && (best < 0 || m_prio[s] < m_prio[best] ||
          (m_prio[s] == m_prio[best] && m_ready_stamp[s] < m_ready_stamp[best]))) begin
        best = s;
      end
    end
    if (best < 0) begin
      best = m_running;
    end else if (m_lock == 8'd0 && best[3:0] != m_running) begin
      r.switch_request = 1'b1;
      m_running = best[3:0];
    end
    r.next_task = best[3:0];
    r.current_task = m_running;
    return r;
  endfunction

  task automatic send_request(cmd_t c, logic [3:0] id, logic [4:0] pr, logic [15:0] dt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_task_id <= id;
    in_priority_req <= pr;
    in_delay_ticks <= dt;
    pending_results.push_back(schedule_model(c, id, pr, dt));
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_slice_reload(logic [7:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_SLICE_RELOAD;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_slice_reload = value;
    @(posedge clk);
  endtask

  // Result channel: the receiver alternates between free running and stall patterns.
  int stall_mode = 0;
  int stall_left = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_mode == 1) begin
      out_ready <= $urandom_range(0, 1);
    end else if (stall_mode == 2 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_result_t exp_r;
    sched_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_switch_request, out_next_task, out_current_task, out_status};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.switch_request !== exp_r.switch_request) begin
          $display("%0t: switch_request expected %0d actual %0d", $time,
                   exp_r.switch_request, got.switch_request);
          errors++;
        end
        if (got.next_task !== exp_r.next_task) begin
          $display("%0t: next_task expected %0d actual %0d", $time,
                   exp_r.next_task, got.next_task);
          errors++;
        end
        if (got.current_task !== exp_r.current_task) begin
          $display("%0t: current_task expected %0d actual %0d", $time,
                   exp_r.current_task, got.current_task);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_TICK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_UNLOCK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_SUSPEND, 4'd4, 5'd0, 16'd0);
    send_request(CMD_RESUME, 4'd0, 5'd0, 16'd0);
    send_request(CMD_CREATE, 4'd3, 5'd5, 16'd0);
    send_request(CMD_CREATE, 4'd3, 5'd1, 16'd0);
    send_request(CMD_CREATE, 4'd8, 5'd5, 16'd0);
    send_request(CMD_CREATE, 4'd15, 5'd31, 16'd0);
    send_request(CMD_CREATE, 4'd9, 5'd0, 16'd0);
    send_request(CMD_CREATE, 4'd10, 5'd0, 16'd0);
    send_request(CMD_DELAY, 4'd0, 5'd0, 16'd2);
    send_request(CMD_DELAY, 4'd0, 5'd0, 16'd2);
    send_request(CMD_SUSPEND, 4'd9, 5'd0, 16'd0);
    send_request(CMD_TICK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_TICK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_DELAY, 4'd0, 5'd0, 16'd0);
    send_request(CMD_DELAY, 4'd0, 5'd0, 16'hFFFF);
    send_request(CMD_LOCK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_SUSPEND, 4'd10, 5'd0, 16'd0);
    send_request(CMD_DELAY, 4'd0, 5'd0, 16'd5);
    send_request(CMD_DELETE, 4'd10, 5'd0, 16'd0);
    send_request(CMD_TICK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_UNLOCK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_DELETE, 4'd0, 5'd0, 16'd0);
    send_request(CMD_DELETE, 4'd0, 5'd0, 16'd0);
  endtask

  task automatic test_suspend_saturation();
    send_request(CMD_CREATE, 4'd12, 5'd2, 16'd0);
    repeat (257) send_request(CMD_SUSPEND, 4'd12, 5'd0, 16'd0);
    repeat (257) send_request(CMD_RESUME, 4'd12, 5'd0, 16'd0);
  endtask

  task automatic test_lock_saturation();
    repeat (257) send_request(CMD_LOCK, 4'd0, 5'd0, 16'd0);
    send_request(CMD_CREATE, 4'd1, 5'd0, 16'd0);
    repeat (257) send_request(CMD_UNLOCK, 4'd0, 5'd0, 16'd0);
  endtask

  task automatic test_random(int count);
    int pick;
    cmd_t c;
    logic [15:0] dt;
    logic [4:0] pr;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) c = CMD_TICK;
      else if (pick < 50) c = CMD_CREATE;
      else if (pick < 62) c = CMD_DELAY;
      else if (pick < 70) c = CMD_SUSPEND;
      else if (pick < 80) c = CMD_RESUME;
      else if (pick < 88) c = CMD_DELETE;
      else if (pick < 94) c = CMD_LOCK;
      else c = CMD_UNLOCK;
      pick = $urandom_range(0, 9);
      dt = (pick < 7) ? 16'($urandom_range(1, 4)) : (pick == 7) ? 16'd0 : 16'($urandom);
      pr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
      send_request(c, 4'($urandom), pr, dt);
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic test_slice_settings();
    logic [7:0] settings [6];
    settings = '{8'd1, 8'd255, 8'd2, 8'd3, 8'($urandom_range(1, 255)), 8'd1};
    foreach (settings[k]) begin
      write_slice_reload(settings[k]);
      test_random(125);
    end
  endtask

  initial begin
    m_slice_reload = SLICE_RST;
    for (int s = 0; s < NSLOTS; s++) begin
      m_valid[s] = 1'b0;
      m_prio[s] = '0;
      m_delay_left[s] = '0;
      m_delayed[s] = 1'b0;
      m_susp[s] = 1'b0;
      m_susp_depth[s] = '0;
      m_slice_left[s] = SLICE_RST;
      m_ready_stamp[s] = '0;
      m_delay_stamp[s] = '0;
    end
    m_valid[0] = 1'b1;
    m_prio[0] = 5'(DEF_PRIO_LEVELS - 1);
    m_counter = 32'd1;
    m_lock = '0;
    m_running = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_suspend_saturation();
    test_lock_saturation();
    test_slice_settings();
    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("rtos_priority_task_scheduler_core verification clean");
    end else begin
      $display("rtos_priority_task_scheduler_core verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("rtos_priority_task_scheduler_core verification failed");
    $finish;
  end

endmodule
